// ===== hdl/utf8p_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8p_pkg: shared types, constants and tables of the UTF-8 charset prober
// Byte classifier, decoder transition table, character length table and the
// confidence percent table.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8p_pkg;

    // Width of the multibyte character counter
    localparam int COUNT_BITS = 8;

    localparam int MIN_MB_W    = 4;
    localparam int SHORTCUT_W  = 7;
    localparam int STATE_W     = 4;
    localparam int CLASS_W     = 4;
    localparam int LEN_W       = 3;
    localparam int COUNT_OUT_W = 8;
    localparam int PCT_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MULTIBYTE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORTCUT_PERCENT = 1'd1;

    // Configuration reset values
    localparam logic [MIN_MB_W-1:0]   MIN_MB_RESET   = 4'd6;
    localparam logic [SHORTCUT_W-1:0] SHORTCUT_RESET = 7'd95;

    localparam logic [PCT_W-1:0] PCT_SURE = 7'd99;
    localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

    // Decoder states
    typedef enum logic [STATE_W-1:0] {
        ST_START = 4'd0,  // between characters
        ST_ERROR = 4'd1,  // invalid sequence, sticky
        ST_FOUND = 4'd2,  // sticky found
        ST_TAIL1 = 4'd3,  // one continuation byte left
        ST_E0    = 4'd4,  // after E0: next byte A0-BF
        ST_TAIL2 = 4'd5,  // two continuation bytes left
        ST_ED    = 4'd6,  // after ED: next byte 80-9F
        ST_F0    = 4'd7,  // after F0: next byte 90-BF
        ST_TAIL3 = 4'd8,  // three continuation bytes left
        ST_F4    = 4'd9   // after F4: next byte 80-8F
    } t_dec_state;

    // Byte classes
    typedef enum logic [CLASS_W-1:0] {
        CL_BAD    = 4'd0,   // illegal byte or escape
        CL_ASCII  = 4'd1,
        CL_CONT_8 = 4'd2,   // 80-8F
        CL_CONT_9 = 4'd3,   // 90-9F
        CL_CONT_A = 4'd4,   // A0-BF
        CL_LEAD2  = 4'd5,   // C2-DF
        CL_E0     = 4'd6,
        CL_LEAD3  = 4'd7,   // E1-EC, EE, EF
        CL_ED     = 4'd8,
        CL_F0     = 4'd9,
        CL_LEAD4  = 4'd10,  // F1-F3
        CL_F4     = 4'd11
    } t_class;

    // One input item as held in the input stage
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       end_of_chunk;
    } t_item;

    // Status of the decoder step, seen by the top level
    typedef struct packed {
        logic                  take;
        logic                  restart;
        t_dec_state            state;
        logic [COUNT_BITS-1:0] count;
    } t_step_stat;

    // Byte to class
    function automatic t_class byte_class(input logic [7:0] b);
        t_class c;
        if (b < 8'h80) begin
            c = (b == 8'h0E || b == 8'h0F || b == 8'h1B) ? CL_BAD : CL_ASCII;
        end else if (b < 8'h90) begin
            c = CL_CONT_8;
        end else if (b < 8'hA0) begin
            c = CL_CONT_9;
        end else if (b < 8'hC0) begin
            c = CL_CONT_A;
        end else if (b < 8'hC2) begin
            c = CL_BAD;
        end else if (b < 8'hE0) begin
            c = CL_LEAD2;
        end else if (b == 8'hE0) begin
            c = CL_E0;
        end else if (b == 8'hED) begin
            c = CL_ED;
        end else if (b < 8'hF0) begin
            c = CL_LEAD3;
        end else if (b == 8'hF0) begin
            c = CL_F0;
        end else if (b < 8'hF4) begin
            c = CL_LEAD4;
        end else if (b == 8'hF4) begin
            c = CL_F4;
        end else begin
            c = CL_BAD;
        end
        return c;
    endfunction

    // Character length begun by a byte of this class
    function automatic logic [LEN_W-1:0] class_len(input t_class c);
        logic [LEN_W-1:0] l;
        case (c)
            CL_ASCII:                  l = 3'd1;
            CL_LEAD2:                  l = 3'd2;
            CL_E0, CL_LEAD3, CL_ED:    l = 3'd3;
            CL_F0, CL_LEAD4, CL_F4:    l = 3'd4;
            default:                   l = 3'd0;
        endcase
        return l;
    endfunction

    // Decoder transition table
    function automatic t_dec_state dec_next(input t_dec_state s, input t_class c);
        t_dec_state n;
        n = ST_ERROR;
        case (s)
            ST_START: begin
                case (c)
                    CL_ASCII: n = ST_START;
                    CL_LEAD2: n = ST_TAIL1;
                    CL_E0:    n = ST_E0;
                    CL_LEAD3: n = ST_TAIL2;
                    CL_ED:    n = ST_ED;
                    CL_F0:    n = ST_F0;
                    CL_LEAD4: n = ST_TAIL3;
                    CL_F4:    n = ST_F4;
                    default:  n = ST_ERROR;
                endcase
            end
            ST_FOUND: n = ST_FOUND;
            ST_TAIL1: if (c inside {CL_CONT_8, CL_CONT_9, CL_CONT_A}) n = ST_START;
            ST_E0:    if (c == CL_CONT_A) n = ST_TAIL1;
            ST_TAIL2: if (c inside {CL_CONT_8, CL_CONT_9, CL_CONT_A}) n = ST_TAIL1;
            ST_ED:    if (c inside {CL_CONT_8, CL_CONT_9}) n = ST_TAIL1;
            ST_F0:    if (c inside {CL_CONT_9, CL_CONT_A}) n = ST_TAIL2;
            ST_TAIL3: if (c inside {CL_CONT_8, CL_CONT_9, CL_CONT_A}) n = ST_TAIL2;
            ST_F4:    if (c == CL_CONT_8) n = ST_TAIL2;
            default:  n = ST_ERROR;
        endcase
        return n;
    endfunction

    // 100 - ceil(100 / 2^count) below the minimum and below 7, else 99
    function automatic logic [PCT_W-1:0] conf_pct(input logic [COUNT_BITS-1:0] cnt,
                                                   input logic [MIN_MB_W-1:0] min_mb);
        logic [PCT_W-1:0] p;
        if (cnt >= COUNT_BITS'(min_mb) || cnt >= COUNT_BITS'(7)) begin
            p = PCT_SURE;
        end else begin
            case (cnt[2:0])
                3'd0:    p = 7'd0;
                3'd1:    p = 7'd50;
                3'd2:    p = 7'd75;
                3'd3:    p = 7'd87;
                3'd4:    p = 7'd93;
                3'd5:    p = 7'd96;
                3'd6:    p = 7'd98;
                default: p = PCT_SURE;
            endcase
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8p_in_stage.sv =====
// ----------------------------------------------------------------------------
// utf8p_in_stage: input register of the prober
// Holds one item until the decoder step takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8p_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic            i_cmd,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_end_of_chunk,
    input  wire logic            i_take,
    output logic                 o_item_valid,
    output utf8p_pkg::t_item     o_item
);
    import utf8p_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Full and not drained this cycle: hold off the sender
    assign o_stall = r_valid && !i_take;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item.cmd          <= i_cmd;
            r_item.data_byte    <= i_data_byte;
            r_item.end_of_chunk <= i_end_of_chunk;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

// ===== hdl/utf8p_step.sv =====
// ----------------------------------------------------------------------------
// utf8p_step: decoder step and result register
// Classifies the byte, steps the decoder, counts multibyte characters,
// decides the verdict and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8p_step (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_item_valid,
    input  wire utf8p_pkg::t_item                    i_item,
    input  wire logic [utf8p_pkg::MIN_MB_W-1:0]      i_min_mb,
    input  wire logic [utf8p_pkg::SHORTCUT_W-1:0]    i_shortcut,
    input  wire logic                                i_stall,
    output logic                                     o_valid,
    output logic                                     o_verdict,
    output logic [utf8p_pkg::STATE_W-1:0]            o_dec_state,
    output logic [utf8p_pkg::COUNT_OUT_W-1:0]        o_multibyte_count,
    output logic [utf8p_pkg::PCT_W-1:0]              o_confidence_percent,
    output utf8p_pkg::t_step_stat                    o_stat
);
    import utf8p_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_SHOW_MAX = COUNT_BITS'(255);

    // Decoder state
    t_dec_state            r_state, n_state;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_found, n_found;
    logic [PCT_W-1:0]      n_pct;

    // Result register
    logic                   r_o_valid;
    logic                   r_verdict;
    logic [STATE_W-1:0]     r_cstate;
    logic [COUNT_OUT_W-1:0] r_count;
    logic [PCT_W-1:0]       r_pct;

    logic   take;
    t_class cls;

    // Step when an item waits and the result slot is free or draining
    assign take = i_item_valid && (!r_o_valid || !i_stall);
    assign cls  = byte_class(i_item.data_byte);

    // One decoder step
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_found = r_found;
        if (i_item.cmd) begin
            n_state = ST_START;
            n_len   = '0;
            n_cnt   = '0;
            n_found = 1'b0;
            n_pct   = PCT_NONE;
        end else begin
            if (r_state == ST_START) begin
                n_len = class_len(cls);
            end
            n_state = dec_next(r_state, cls);
            if (n_state == ST_FOUND) begin
                n_found = 1'b1;
            end else if (n_state == ST_START && n_len >= LEN_W'(2)) begin
                if (r_cnt != CNT_MAX) begin
                    n_cnt = r_cnt + COUNT_BITS'(1);
                end
            end
            n_pct = conf_pct(n_cnt, i_min_mb);
            // end-of-chunk decision
            if (i_item.end_of_chunk && !n_found) begin
                if (n_cnt >= COUNT_BITS'(i_min_mb) || n_pct > i_shortcut) begin
                    n_found = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_START;
            r_len     <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (take) begin
                r_state <= n_state;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
                r_found <= n_found;
            end
            if (take) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_verdict <= n_found;
            r_cstate  <= n_state;
            r_count   <= (n_cnt > CNT_SHOW_MAX) ? 8'd255 : COUNT_OUT_W'(n_cnt);
            r_pct     <= n_pct;
        end
    end

    assign o_valid              = r_o_valid;
    assign o_verdict            = r_verdict;
    assign o_dec_state          = r_cstate;
    assign o_multibyte_count    = r_count;
    assign o_confidence_percent = r_pct;

    assign o_stat = '{take: take, restart: i_item.cmd, state: r_state, count: r_cnt};

endmodule

`default_nettype wire

// ===== hdl/utf8_charset_prober.sv =====
// ----------------------------------------------------------------------------
// utf8_charset_prober: UTF-8 charset prober, top level
// Feed text bytes on the input channel (i_valid / o_stall): each item is
// either a data byte or a restart command; end_of_chunk on a byte asks for
// a verdict decision. Each item gives exactly one result item on the output
// channel (o_valid / i_stall): verdict, decoder state, multibyte count and
// confidence percent after that byte.
// An accepted item is loaded into the input register and then, once the
// result slot is free or draining, into the result register, raising o_valid.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the held result stays put and the input register
// fills; the sender is stalled only once both are full.
// Reset clears the decoder and counters and loads min_multibyte 6 and
// shortcut_percent 95. Write registers through i_cfg_we while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_charset_prober (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_cmd,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_end_of_chunk,
    // result channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_verdict,
    output logic [utf8p_pkg::STATE_W-1:0]           o_dec_state,
    output logic [utf8p_pkg::COUNT_OUT_W-1:0]       o_multibyte_count,
    output logic [utf8p_pkg::PCT_W-1:0]             o_confidence_percent,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [utf8p_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [utf8p_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import utf8p_pkg::*;

    logic [MIN_MB_W-1:0]   r_min_mb;
    logic [SHORTCUT_W-1:0] r_shortcut;

    logic       item_valid;
    t_item      item;
    t_step_stat stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mb   <= MIN_MB_RESET;
            r_shortcut <= SHORTCUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_MULTIBYTE:    r_min_mb   <= i_cfg_data[MIN_MB_W-1:0];
                CFG_SHORTCUT_PERCENT: r_shortcut <= i_cfg_data[SHORTCUT_W-1:0];
                default: ;
            endcase
        end
    end

    utf8p_in_stage u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_end_of_chunk (i_end_of_chunk),
        .i_take         (stat.take),
        .o_item_valid   (item_valid),
        .o_item         (item)
    );

    utf8p_step u_step (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_item_valid         (item_valid),
        .i_item               (item),
        .i_min_mb             (r_min_mb),
        .i_shortcut           (r_shortcut),
        .i_stall              (i_stall),
        .o_valid              (o_valid),
        .o_verdict            (o_verdict),
        .o_dec_state          (o_dec_state),
        .o_multibyte_count    (o_multibyte_count),
        .o_confidence_percent (o_confidence_percent),
        .o_stat               (stat)
    );

    // Error is sticky until a restart
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.state == ST_ERROR && !(stat.take && stat.restart))
        |=> stat.state == ST_ERROR)
        else $error("decoder left the error state without a restart");

    // Counter only grows, by at most one, unless restarted
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.take && stat.restart)
        |=> (stat.count == $past(stat.count) ||
             stat.count == $past(stat.count) + COUNT_BITS'(1)))
        else $error("multibyte counter moved unexpectedly");

    // A restart item reports a cleared prober
    a_restart_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.take && stat.restart)
        |=> (o_valid && !o_verdict && o_dec_state == ST_START &&
             o_multibyte_count == '0 && o_confidence_percent == PCT_NONE))
        else $error("restart result not cleared");

    // A step always leaves a result behind
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.take |=> o_valid)
        else $error("decoder step without result");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the UTF-8 charset prober
// Drives bytes and restart commands over the valid/stall input channel and
// checks every result item against an in-bench predictor of the decoder,
// the multibyte counter and the verdict logic. It covers directed character
// forms, special cases, random text under several register settings, a long
// receiver hold-off and multibyte counter saturation.
// ----------------------------------------------------------------------------
module testbench;

    import utf8p_pkg::*;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Expected contents of one result item
    typedef struct packed {
        logic                   verdict;
        logic [STATE_W-1:0]     dec_state;
        logic [COUNT_OUT_W-1:0] count;
        logic [PCT_W-1:0]       pct;
    } t_prober_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_cmd;
    logic [7:0]             i_data_byte;
    logic                   i_end_of_chunk;
    logic                   o_valid;
    logic                   i_stall;
    logic                   o_verdict;
    logic [STATE_W-1:0]     o_dec_state;
    logic [COUNT_OUT_W-1:0] o_multibyte_count;
    logic [PCT_W-1:0]       o_confidence_percent;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Predictor state and register copies
    t_dec_state             text_state;
    logic [LEN_W-1:0]       text_len;
    logic [COUNT_BITS-1:0]  mb_count;
    logic                   found_seen;
    logic [MIN_MB_W-1:0]    cfg_min_mb;
    logic [SHORTCUT_W-1:0]  cfg_shortcut;

    t_prober_result         pending_results[$];
    int                     mismatch_count;

    // Traffic shaping
    bit                     tx_idle_en;
    bit                     rx_idle_en;
    int                     hold_left;
    int                     burst_left;

    utf8_charset_prober u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_cmd                (i_cmd),
        .i_data_byte          (i_data_byte),
        .i_end_of_chunk       (i_end_of_chunk),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_verdict            (o_verdict),
        .o_dec_state          (o_dec_state),
        .o_multibyte_count    (o_multibyte_count),
        .o_confidence_percent (o_confidence_percent),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Byte class by high nibble, then the exceptions within it
    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        if (!b[7]) begin
            c = (b == 8'h0E || b == 8'h0F || b == 8'h1B) ? CL_BAD : CL_ASCII;
        end else begin
            case (b[7:4])
                4'h8:       c = CL_CONT_8;
                4'h9:       c = CL_CONT_9;
                4'hA, 4'hB: c = CL_CONT_A;
                4'hC:       c = (b[3:1] == 3'b000) ? CL_BAD : CL_LEAD2;  // C0, C1 overlong
                4'hD:       c = CL_LEAD2;
                4'hE: begin
                    if (b[3:0] == 4'h0)      c = CL_E0;
                    else if (b[3:0] == 4'hD) c = CL_ED;
                    else                     c = CL_LEAD3;
                end
                default: begin
                    case (b[3:0])
                        4'h0:             c = CL_F0;
                        4'h1, 4'h2, 4'h3: c = CL_LEAD4;
                        4'h4:             c = CL_F4;
                        default:          c = CL_BAD;
                    endcase
                end
            endcase
        end
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] lead_len(input t_class c);
        case (c)
            CL_ASCII:                return 3'd1;
            CL_LEAD2:                return 3'd2;
            CL_E0, CL_LEAD3, CL_ED:  return 3'd3;
            CL_F0, CL_LEAD4, CL_F4:  return 3'd4;
            default:                 return 3'd0;
        endcase
    endfunction

    // Decoder step; anything not listed falls into the sticky error state
    function automatic t_dec_state decode_next(input t_dec_state s, input t_class c);
        logic any_cont;
        t_dec_state n;
        any_cont = (c == CL_CONT_8 || c == CL_CONT_9 || c == CL_CONT_A);
        n = ST_ERROR;
        case (s)
            ST_START: begin
                case (c)
                    CL_ASCII: n = ST_START;
                    CL_LEAD2: n = ST_TAIL1;
                    CL_E0:    n = ST_E0;
                    CL_LEAD3: n = ST_TAIL2;
                    CL_ED:    n = ST_ED;
                    CL_F0:    n = ST_F0;
                    CL_LEAD4: n = ST_TAIL3;
                    CL_F4:    n = ST_F4;
                    default:  n = ST_ERROR;
                endcase
            end
            ST_FOUND: n = ST_FOUND;
            ST_TAIL1: if (any_cont) n = ST_START;
            ST_E0:    if (c == CL_CONT_A) n = ST_TAIL1;
            ST_TAIL2: if (any_cont) n = ST_TAIL1;
            ST_ED:    if (c == CL_CONT_8 || c == CL_CONT_9) n = ST_TAIL1;
            ST_F0:    if (c == CL_CONT_9 || c == CL_CONT_A) n = ST_TAIL2;
            ST_TAIL3: if (any_cont) n = ST_TAIL2;
            ST_F4:    if (c == CL_CONT_8) n = ST_TAIL2;
            default:  n = ST_ERROR;
        endcase
        return n;
    endfunction

    // 100 - ceil(100 / 2^cnt), pinned at 99 once the minimum or 7 is reached
    function automatic logic [PCT_W-1:0] confidence(input logic [COUNT_BITS-1:0] cnt);
        int n;
        if (cnt >= COUNT_BITS'(cfg_min_mb) || cnt >= 7)
            return 7'd99;
        n = int'(cnt);
        return PCT_W'(100 - ((100 + (1 << n) - 1) >> n));
    endfunction

    function automatic t_prober_result prober_step(input logic cmd, input logic [7:0] b,
                                                   input logic eoc);
        t_prober_result r;
        t_class cls;
        if (cmd == CMD_RESTART) begin
            text_state = ST_START;
            text_len   = '0;
            mb_count   = '0;
            found_seen = 1'b0;
            r.pct      = '0;
        end else begin
            cls = classify(b);
            if (text_state == ST_START)
                text_len = lead_len(cls);
            text_state = decode_next(text_state, cls);
            if (text_state == ST_FOUND)
                found_seen = 1'b1;
            else if (text_state == ST_START && text_len >= 2 && mb_count != '1)
                mb_count = mb_count + 1'b1;
            // end-of-chunk decision
            if (eoc && !found_seen &&
                (mb_count >= COUNT_BITS'(cfg_min_mb) || confidence(mb_count) > cfg_shortcut))
                found_seen = 1'b1;
            r.pct = confidence(mb_count);
        end
        r.verdict   = found_seen;
        r.dec_state = text_state;
        r.count     = (mb_count > 255) ? 8'hFF : COUNT_OUT_W'(mb_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_prober_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                    mismatch_count++;
                end
                if (o_dec_state !== want.dec_state) begin
                    $error("dec_state: expected %0d, got %0d",
                           want.dec_state, o_dec_state);
                    mismatch_count++;
                end
                if (o_multibyte_count !== want.count) begin
                    $error("multibyte_count: expected %0d, got %0d",
                           want.count, o_multibyte_count);
                    mismatch_count++;
                end
                if (o_confidence_percent !== want.pct) begin
                    $error("confidence_percent: expected %0d, got %0d",
                           want.pct, o_confidence_percent);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver stall: long hold-off first, then random bursts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (burst_left > 0) begin
            i_stall <= 1'b1;
            burst_left--;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            burst_left = $urandom_range(0, 9);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item, wait until taken, then record its expected result
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic eoc);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_data_byte    <= b;
        i_end_of_chunk <= eoc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(prober_step(cmd, b, eoc));
    endtask

    // Stop offering and wait until every result is back
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MIN_MULTIBYTE)
            cfg_min_mb = MIN_MB_W'(value);
        else
            cfg_shortcut = SHORTCUT_W'(value);
    endtask

    // Mostly well-formed characters of min_len..max_len bytes, with noise
    // bytes, restarts and truncated characters mixed in
    task automatic send_random_text(input int n_items, input int noise_pct,
                                    input int restart_pct, input int min_len,
                                    input int max_len);
        logic [7:0] seq [4];
        int sent;
        int len;
        int n;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < restart_pct) begin
                send_item(CMD_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end else if (r < restart_pct + noise_pct) begin
                send_item(CMD_DATA, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                sent++;
            end else begin
                len = $urandom_range(min_len, max_len);
                seq[1] = 8'($urandom_range(8'h80, 8'hBF));
                seq[2] = 8'($urandom_range(8'h80, 8'hBF));
                seq[3] = 8'($urandom_range(8'h80, 8'hBF));
                case (len)
                    1: begin
                        do seq[0] = 8'($urandom_range(0, 8'h7F));
                        while (seq[0] == 8'h0E || seq[0] == 8'h0F || seq[0] == 8'h1B);
                    end
                    2: seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
                    3: begin
                        seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
                        if (seq[0] == 8'hE0)      seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
                        else if (seq[0] == 8'hED) seq[1] = 8'($urandom_range(8'h80, 8'h9F));
                    end
                    default: begin
                        seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
                        if (seq[0] == 8'hF0)      seq[1] = 8'($urandom_range(8'h90, 8'hBF));
                        else if (seq[0] == 8'hF4) seq[1] = 8'($urandom_range(8'h80, 8'h8F));
                    end
                endcase
                n = len;
                if (noise_pct > 0 && n > 1 && $urandom_range(0, 9) == 0)
                    n = $urandom_range(1, n - 1);
                for (int k = 0; k < n && sent < n_items; k++) begin
                    send_item(CMD_DATA, seq[k], $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One of each character form under reset settings, then an illegal byte
    task automatic test_char_forms;
        send_item(CMD_RESTART, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'hC2, 1'b0);
        send_item(CMD_DATA, 8'h80, 1'b0);
        send_item(CMD_DATA, 8'hE0, 1'b0);
        send_item(CMD_DATA, 8'hA0, 1'b0);
        send_item(CMD_DATA, 8'h80, 1'b0);
        send_item(CMD_DATA, 8'hF0, 1'b0);
        send_item(CMD_DATA, 8'h90, 1'b0);
        send_item(CMD_DATA, 8'h80, 1'b0);
        send_item(CMD_DATA, 8'h80, 1'b0);
        send_item(CMD_DATA, 8'hF4, 1'b0);
        send_item(CMD_DATA, 8'h8F, 1'b0);
        send_item(CMD_DATA, 8'hBF, 1'b0);
        send_item(CMD_DATA, 8'hBF, 1'b1);
        send_item(CMD_DATA, 8'hFF, 1'b1);
        drain();
    endtask

    task automatic test_special_cases;
        // zero minimum: any end of chunk on a data byte decides found
        write_reg(CFG_MIN_MULTIBYTE, 0);
        send_item(CMD_RESTART, 8'hFF, 1'b1);
        send_item(CMD_DATA, 8'h41, 1'b1);
        // shortcut 0: a single multibyte character is enough
        write_reg(CFG_MIN_MULTIBYTE, 15);
        write_reg(CFG_SHORTCUT_PERCENT, 0);
        send_item(CMD_RESTART, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'hC2, 1'b0);
        send_item(CMD_DATA, 8'h80, 1'b1);
        // F0 followed by 80 is an error; error stays and the count freezes
        write_reg(CFG_SHORTCUT_PERCENT, 127);
        send_item(CMD_RESTART, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'hF0, 1'b0);
        send_item(CMD_DATA, 8'h80, 1'b0);
        send_item(CMD_DATA, 8'hC2, 1'b0);
        send_item(CMD_DATA, 8'h80, 1'b1);
        drain();
    endtask

    task automatic test_random_settings;
        int min_set [5]  = '{1, 15, 0, 7, 3};
        int pct_set [5]  = '{0, 127, 64, 100, 99};
        for (int i = 0; i < 5; i++) begin
            write_reg(CFG_MIN_MULTIBYTE, min_set[i]);
            write_reg(CFG_SHORTCUT_PERCENT, pct_set[i]);
            send_random_text(12, 15, 4, 1, 4);
            drain();
        end
    endtask

    // Receiver holds off long enough that the block backs up into the sender
    task automatic test_backpressure;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_left  = 40;
        send_random_text(24, 0, 0, 1, 4);
        drain();
    endtask

    // Enough two-byte characters to pin the counter at its maximum
    task automatic test_counter_saturation;
        write_reg(CFG_MIN_MULTIBYTE, 15);
        write_reg(CFG_SHORTCUT_PERCENT, 100);
        send_item(CMD_RESTART, 8'h00, 1'b0);
        send_random_text(516, 0, 0, 2, 2);
        drain();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = CMD_DATA;
        i_data_byte    = '0;
        i_end_of_chunk = 1'b0;
        i_stall        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_MIN_MULTIBYTE;
        i_cfg_data     = '0;
        text_state     = ST_START;
        text_len       = '0;
        mb_count       = '0;
        found_seen     = 1'b0;
        cfg_min_mb     = MIN_MB_RESET;
        cfg_shortcut   = SHORTCUT_RESET;
        mismatch_count = 0;
        hold_left      = 0;
        burst_left     = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_char_forms();
        test_special_cases();
        test_random_settings();
        test_backpressure();
        test_counter_saturation();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/utf8p_pkg.sv
hdl/utf8p_in_stage.sv
hdl/utf8p_step.sv
hdl/utf8_charset_prober.sv
dv/testbench.sv
